### src/tdvp_pkg.sv
// Shared constants, word types and register codes of the top-down view projection.
package tdvp_pkg;

  // defaults for the top-level parameters
  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // field widths
  localparam int COORD_W = 32;
  localparam int YAW_W   = 16;
  localparam int CFG_W   = 12;
  localparam int OUT_W   = 16;
  localparam int IDX_W   = 2;

  // trig arithmetic: angles, squares and products in Q30
  localparam int PH_W    = 32;
  localparam int TRIG_Q  = 30;
  localparam int TRIG_W  = 30;
  localparam int T_W     = 31;
  localparam int GUARD   = 14;
  localparam logic [32:0]    TWO_PI_Q30 = 33'd6746518852;
  localparam logic [T_W-1:0] TRIG_ONE   = T_W'(1) << TRIG_Q;

  // Horner factorial ratios, highest term first
  localparam int SIN_TERMS = 4;
  localparam int COS_TERMS = 5;
  localparam int SIN_DIV [SIN_TERMS] = '{72, 42, 20, 6};
  localparam int COS_DIV [COS_TERMS] = '{90, 56, 30, 12, 2};

  // quotient bits produced by the divider row
  localparam int QB = 17;

  // register indexes
  localparam logic [IDX_W-1:0] REG_VIEW_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_VIEW_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_RANGE       = 2'd2;

  localparam logic [CFG_W-1:0] VIEW_WIDTH_RST  = 12'd500;
  localparam logic [CFG_W-1:0] VIEW_HEIGHT_RST = 12'd500;
  localparam logic [CFG_W-1:0] RANGE_RST       = 12'd25;

  typedef struct packed {
    logic [TRIG_W-1:0] x2;
    logic [T_W-1:0]    t;
  } horner_t;

  typedef struct packed {
    logic [CFG_W-1:0] rem;
    logic [QB-1:0]    low;
    logic [QB-1:0]    quo;
    logic             neg;
    logic             ovf;
  } div_t;

endpackage

### src/tdvp_delay.sv
// Shift line of DEPTH registers that delays a word, advancing only while en is high.
module tdvp_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

### src/tdvp_horner_cell.sv
// One Horner step of the sine or cosine series: t_out = 1 - ((x2 * t) >> 30) / DIV.
module tdvp_horner_cell #(
  parameter int DIV = 2
) (
  input  logic              clk,
  input  logic              en,
  input  tdvp_pkg::horner_t din,
  output tdvp_pkg::horner_t dout
);

  localparam int TW = tdvp_pkg::TRIG_W;
  localparam int TT = tdvp_pkg::T_W;
  localparam int K  = tdvp_pkg::TRIG_Q + $clog2(DIV);
  // ceil(2^K / DIV): exact floor quotient for any dividend below 2^30
  localparam logic [63:0] RECIP_FULL = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [TT-1:0] RECIP = RECIP_FULL[TT-1:0];

  logic [TW-1:0]    p;
  logic [TW-1:0]    x2_a;
  logic [TW+TT-1:0] prod_a;
  logic [TW+TT-1:0] prod_b;

  assign prod_a = (TW+TT)'(din.x2) * (TW+TT)'(din.t);
  assign prod_b = (TW+TT)'(p) * (TW+TT)'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      p       <= prod_a[tdvp_pkg::TRIG_Q +: TW];
      x2_a    <= din.x2;
      dout.x2 <= x2_a;
      dout.t  <= tdvp_pkg::TRIG_ONE - TT'(prod_b >> K);
    end
  end

endmodule

### src/tdvp_div_cell.sv
// One restoring-division step: shifts in a dividend bit, emits one quotient bit.
module tdvp_div_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tdvp_pkg::CFG_W-1:0] divisor,
  input  tdvp_pkg::div_t             din,
  output tdvp_pkg::div_t             dout
);

  localparam int CW = tdvp_pkg::CFG_W;
  localparam int QB = tdvp_pkg::QB;

  logic [CW:0] r2;
  logic [CW:0] diff;
  logic        ge;

  assign r2   = {din.rem, din.low[QB-1]};
  assign ge   = r2 >= {1'b0, divisor};
  assign diff = r2 - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem <= ge ? diff[CW-1:0] : r2[CW-1:0];
      dout.low <= din.low << 1;
      dout.quo <= {din.quo[QB-2:0], ge};
      dout.neg <= din.neg;
      dout.ovf <= din.ovf;
    end
  end

endmodule

### src/top_down_view_projection.sv
// Top-down view projection: world point to view pixel through a row of pipeline cells.
//
// Input channel point_valid/point_ready carries one word per point: point_x, point_z,
// cam_x, cam_z (signed fixed-point metres) and cam_yaw (1/65536 turn).
// Output channel pixel_valid/pixel_ready returns one word per point: pixel_x,
// pixel_y and clipped, in input order.
// Throughput: one point per cycle while the output does not stall. Every series step of
// the sine/cosine (Horner cell), every partial-product stage of the rotation and
// scaling, and every quotient bit of the divide by the range (divider cell) is
// registered, so the depth is set by the 17-cell divider row and the cosine row
// of the 9 trig cells, beside which the shorter sine row runs.
// Configuration: cfg_write with cfg_index 0/1/2 writes view_width, view_height or
// range_meters in the same cycle; write only while no point is in flight.
// Reset (rst, synchronous) empties the pipeline and loads 500, 500 and 25.
// Stall: when a result waits unread and the last stage holds another, the whole
// row holds and point_ready drops; otherwise points keep entering.
module top_down_view_projection #(
  parameter int ANGLE_BITS = tdvp_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = tdvp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               point_valid,
  output logic                               point_ready,
  input  logic signed [tdvp_pkg::COORD_W-1:0] point_x,
  input  logic signed [tdvp_pkg::COORD_W-1:0] point_z,
  input  logic signed [tdvp_pkg::COORD_W-1:0] cam_x,
  input  logic signed [tdvp_pkg::COORD_W-1:0] cam_z,
  input  logic        [tdvp_pkg::YAW_W-1:0]   cam_yaw,
  output logic                               pixel_valid,
  input  logic                               pixel_ready,
  output logic signed [tdvp_pkg::OUT_W-1:0]   pixel_x,
  output logic signed [tdvp_pkg::OUT_W-1:0]   pixel_y,
  output logic                               clipped,
  input  logic                               cfg_write,
  input  logic        [tdvp_pkg::IDX_W-1:0]   cfg_index,
  input  logic        [tdvp_pkg::CFG_W-1:0]   cfg_data
);

  localparam int CW     = tdvp_pkg::CFG_W;
  localparam int TW     = tdvp_pkg::TRIG_W;
  localparam int TT     = tdvp_pkg::T_W;
  localparam int TQ     = tdvp_pkg::TRIG_Q;
  localparam int PH_W   = tdvp_pkg::PH_W;
  localparam int QB     = tdvp_pkg::QB;
  localparam int OW     = tdvp_pkg::OUT_W;
  localparam int NS     = tdvp_pkg::SIN_TERMS;
  localparam int NC     = tdvp_pkg::COS_TERMS;
  localparam int DZ_W   = tdvp_pkg::COORD_W + 1;
  localparam int SC_W   = TT + 1;
  localparam int SPLIT  = 16;
  localparam int HALF_W = DZ_W - SPLIT;
  localparam int PP_W   = HALF_W + SC_W;
  localparam int ROT_W  = PP_W + SPLIT;
  localparam int ROT_SH = TQ - tdvp_pkg::GUARD;
  localparam int FL_W   = ROT_W - ROT_SH;
  localparam int NUM_W  = FL_W + 1;
  localparam int MAG_W  = FL_W;
  localparam int LO_W   = 25;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PROD_W = CW + MAG_W;
  localparam int DS     = FRAC_BITS + tdvp_pkg::GUARD + 1;
  localparam int M_W    = PROD_W - DS;
  localparam int HQ_W   = M_W - QB;
  localparam int QS_DLY = 2 + 2 * NC;
  localparam int NUM_ST = 22 + QB;
  localparam int LAST   = NUM_ST - 1;

  localparam logic [PH_W-1:0] PHASE_MASK = ~((PH_W'(1) << (PH_W - ANGLE_BITS)) - PH_W'(1));
  localparam logic [TW-1:0]   HALF_QUAD  = TW'(1) << (TW - 1);
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;
  localparam logic signed [OW-1:0] PIX_MAX = OW'((1 << (OW - 1)) - 1);
  localparam logic signed [OW-1:0] PIX_MIN = OW'(1 << (OW - 1));

  // configuration
  logic [CW-1:0] view_width, view_height, range_meters;
  logic [CW-1:0] rng;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width   <= tdvp_pkg::VIEW_WIDTH_RST;
      view_height  <= tdvp_pkg::VIEW_HEIGHT_RST;
      range_meters <= tdvp_pkg::RANGE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tdvp_pkg::REG_VIEW_WIDTH:  view_width   <= cfg_data;
        tdvp_pkg::REG_VIEW_HEIGHT: view_height  <= cfg_data;
        tdvp_pkg::REG_RANGE:       range_meters <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rng = (range_meters == '0) ? CW'(1) : range_meters;

  // pipeline control
  logic [NUM_ST-1:0] vld;
  logic              en;

  assign en          = !vld[LAST] || !pixel_valid || pixel_ready;
  assign point_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], point_valid};
    end
  end

  // stage 0: differences and folded phase
  logic [PH_W-1:0]        phase;
  logic [TW-1:0]          r_raw, r_fold;
  logic                   fold;
  logic signed [DZ_W-1:0] dz0, dx0;
  logic [TW-1:0]          r0;
  logic [1:0]             quad0;
  logic                   swap0;

  assign phase  = {cam_yaw, (PH_W - tdvp_pkg::YAW_W)'(0)} & PHASE_MASK;
  assign r_raw  = phase[TW-1:0];
  assign fold   = r_raw > HALF_QUAD;
  assign r_fold = fold ? TW'((TW + 1)'(1) << TW) - r_raw : r_raw;

  always_ff @(posedge clk) begin
    if (en) begin
      dz0   <= DZ_W'(cam_z) - DZ_W'(point_z);
      dx0   <= DZ_W'(cam_x) - DZ_W'(point_x);
      r0    <= r_fold;
      quad0 <= phase[PH_W-1 -: 2];
      swap0 <= fold;
    end
  end

  // stages 1-2: angle in radians and its square
  logic [62:0]   th_full;
  logic [2*TW:0] sq_full;
  logic [TW-1:0] theta1, theta2, x2_2;

  assign th_full = 63'(r0) * 63'(tdvp_pkg::TWO_PI_Q30) + (63'(1) << (PH_W - 1));
  assign sq_full = (2*TW+1)'(theta1) * (2*TW+1)'(theta1) + ((2*TW+1)'(1) << (TQ - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      theta1 <= th_full[PH_W +: TW];
      theta2 <= theta1;
      x2_2   <= sq_full[TQ +: TW];
    end
  end

  // Horner rows for sine and cosine
  tdvp_pkg::horner_t sin_w [NS+1];
  tdvp_pkg::horner_t cos_w [NC+1];

  assign sin_w[0] = '{x2: x2_2, t: tdvp_pkg::TRIG_ONE};
  assign cos_w[0] = '{x2: x2_2, t: tdvp_pkg::TRIG_ONE};

  for (genvar i = 0; i < NS; i++) begin : g_sin
    tdvp_horner_cell #(.DIV(tdvp_pkg::SIN_DIV[i])) u_cell (
      .clk  (clk),
      .en   (en),
      .din  (sin_w[i]),
      .dout (sin_w[i+1])
    );
  end

  for (genvar i = 0; i < NC; i++) begin : g_cos
    tdvp_horner_cell #(.DIV(tdvp_pkg::COS_DIV[i])) u_cell (
      .clk  (clk),
      .en   (en),
      .din  (cos_w[i]),
      .dout (cos_w[i+1])
    );
  end

  // sine = theta * series, then one step to line up with cosine
  logic [TW-1:0]    theta10;
  logic [TW+TT-1:0] s_prod;
  logic [TT-1:0]    s11, s12;

  tdvp_delay #(.WIDTH(TW), .DEPTH(2 * NS)) u_theta_dly (
    .clk (clk),
    .en  (en),
    .d   (theta2),
    .q   (theta10)
  );

  assign s_prod = (TW+TT)'(theta10) * (TW+TT)'(sin_w[NS].t);

  always_ff @(posedge clk) begin
    if (en) begin
      s11 <= s_prod[TQ +: TT];
      s12 <= s11;
    end
  end

  // stage 13: octant swap and quadrant signs
  logic [1:0]             quad12;
  logic                   swap12;
  logic [TT-1:0]          sa, ca;
  logic signed [SC_W-1:0] sp, cp, s_q, c_q, s13, c13;

  tdvp_delay #(.WIDTH(3), .DEPTH(QS_DLY)) u_quad_dly (
    .clk (clk),
    .en  (en),
    .d   ({quad0, swap0}),
    .q   ({quad12, swap12})
  );

  assign sa = swap12 ? cos_w[NC].t : s12;
  assign ca = swap12 ? s12 : cos_w[NC].t;
  assign sp = $signed({1'b0, sa});
  assign cp = $signed({1'b0, ca});

  always_comb begin
    unique case (quad12)
      QUAD_I:   begin s_q = sp;  c_q = cp;  end
      QUAD_II:  begin s_q = cp;  c_q = -sp; end
      QUAD_III: begin s_q = -sp; c_q = -cp; end
      QUAD_IV:  begin s_q = -cp; c_q = sp;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s13 <= s_q;
      c13 <= c_q;
    end
  end

  // stages 14-16: rotation from 17x32 partial products
  logic [2*DZ_W-1:0]        dd13;
  logic signed [DZ_W-1:0]   dz13, dx13;
  logic signed [HALF_W-1:0] dzl, dzh, dxl, dxh;
  logic signed [PP_W-1:0]   zc_l, zc_h, xs_l, xs_h, zs_l, zs_h, xc_l, xc_h;
  logic signed [ROT_W-1:0]  zc15, xs15, zs15, xc15, fwd_full, lat_full;
  logic signed [FL_W-1:0]   fwd16, lat16;

  tdvp_delay #(.WIDTH(2 * DZ_W), .DEPTH(QS_DLY + 1)) u_diff_dly (
    .clk (clk),
    .en  (en),
    .d   ({dz0, dx0}),
    .q   (dd13)
  );

  assign dz13 = $signed(dd13[2*DZ_W-1:DZ_W]);
  assign dx13 = $signed(dd13[DZ_W-1:0]);
  assign dzl  = $signed({1'b0, dz13[SPLIT-1:0]});
  assign dzh  = $signed(dz13[DZ_W-1:SPLIT]);
  assign dxl  = $signed({1'b0, dx13[SPLIT-1:0]});
  assign dxh  = $signed(dx13[DZ_W-1:SPLIT]);

  assign fwd_full = zc15 - xs15;
  assign lat_full = zs15 + xc15;

  always_ff @(posedge clk) begin
    if (en) begin
      zc_l  <= dzl * c13;
      zc_h  <= dzh * c13;
      xs_l  <= dxl * s13;
      xs_h  <= dxh * s13;
      zs_l  <= dzl * s13;
      zs_h  <= dzh * s13;
      xc_l  <= dxl * c13;
      xc_h  <= dxh * c13;
      zc15  <= (ROT_W'(zc_h) <<< SPLIT) + ROT_W'(zc_l);
      xs15  <= (ROT_W'(xs_h) <<< SPLIT) + ROT_W'(xs_l);
      zs15  <= (ROT_W'(zs_h) <<< SPLIT) + ROT_W'(zs_l);
      xc15  <= (ROT_W'(xc_h) <<< SPLIT) + ROT_W'(xc_l);
      // dropping the low bits of a two's-complement word is a floor
      fwd16 <= fwd_full[ROT_W-1:ROT_SH];
      lat16 <= lat_full[ROT_W-1:ROT_SH];
    end
  end

  // stages 17-20: offset numerators, magnitudes, scale by width/height, drop 2^DS
  logic signed [NUM_W-1:0] a17, b17;
  logic                    neg_a18, neg_b18, neg_a19, neg_b19, neg_a20, neg_b20;
  logic [MAG_W-1:0]        mag_a18, mag_b18;
  logic [CW+LO_W-1:0]      wa_lo, hb_lo;
  logic [CW+HI_W-1:0]      wa_hi, hb_hi;
  logic [PROD_W-1:0]       wa_full, hb_full;
  logic [M_W-1:0]          m_y20, m_x20;

  assign wa_full = (PROD_W'(wa_hi) << LO_W) + PROD_W'(wa_lo);
  assign hb_full = (PROD_W'(hb_hi) << LO_W) + PROD_W'(hb_lo);

  always_ff @(posedge clk) begin
    if (en) begin
      a17     <= $signed(NUM_W'(rng) << DS) - NUM_W'(fwd16);
      b17     <= $signed(NUM_W'(rng) << (DS - 1)) - NUM_W'(lat16);
      neg_a18 <= a17[NUM_W-1];
      neg_b18 <= b17[NUM_W-1];
      mag_a18 <= MAG_W'(a17[NUM_W-1] ? -a17 : a17);
      mag_b18 <= MAG_W'(b17[NUM_W-1] ? -b17 : b17);
      wa_lo   <= (CW+LO_W)'(view_width) * (CW+LO_W)'(mag_a18[LO_W-1:0]);
      wa_hi   <= (CW+HI_W)'(view_width) * (CW+HI_W)'(mag_a18[MAG_W-1:LO_W]);
      hb_lo   <= (CW+LO_W)'(view_height) * (CW+LO_W)'(mag_b18[LO_W-1:0]);
      hb_hi   <= (CW+HI_W)'(view_height) * (CW+HI_W)'(mag_b18[MAG_W-1:LO_W]);
      neg_a19 <= neg_a18;
      neg_b19 <= neg_b18;
      m_y20   <= M_W'(wa_full >> DS);
      m_x20   <= M_W'(hb_full >> DS);
      neg_a20 <= neg_a19;
      neg_b20 <= neg_b19;
    end
  end

  // stage 21: divider set-up; a quotient of 2^17 or more only saturates
  tdvp_pkg::div_t div_y [QB+1];
  tdvp_pkg::div_t div_x [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      div_y[0].rem <= m_y20[QB +: CW];
      div_y[0].low <= m_y20[QB-1:0];
      div_y[0].quo <= '0;
      div_y[0].neg <= neg_a20;
      div_y[0].ovf <= m_y20[M_W-1:QB] >= HQ_W'(rng);
      div_x[0].rem <= m_x20[QB +: CW];
      div_x[0].low <= m_x20[QB-1:0];
      div_x[0].quo <= '0;
      div_x[0].neg <= neg_b20;
      div_x[0].ovf <= m_x20[M_W-1:QB] >= HQ_W'(rng);
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    tdvp_div_cell u_cell_y (
      .clk     (clk),
      .en      (en),
      .divisor (rng),
      .din     (div_y[i]),
      .dout    (div_y[i+1])
    );
    tdvp_div_cell u_cell_x (
      .clk     (clk),
      .en      (en),
      .divisor (rng),
      .din     (div_x[i]),
      .dout    (div_x[i+1])
    );
  end

  // sign and saturation; result is {clip, pixel}
  function automatic logic [OW:0] finish(input tdvp_pkg::div_t w);
    logic [QB-1:0] lim;
    logic          clip;
    logic [OW-1:0] v;
    lim  = w.neg ? QB'(1 << (OW - 1)) : QB'((1 << (OW - 1)) - 1);
    clip = w.ovf || (w.quo > lim);
    if (clip) begin
      v = w.neg ? PIX_MIN : PIX_MAX;
    end else begin
      v = w.neg ? OW'(QB'(0) - w.quo) : OW'(w.quo);
    end
    return {clip, v};
  endfunction

  logic [OW:0] fin_x, fin_y;

  assign fin_x = finish(div_x[QB]);
  assign fin_y = finish(div_y[QB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (en && vld[LAST]) begin
      pixel_valid <= 1'b1;
    end else if (pixel_ready) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[LAST]) begin
      pixel_x <= $signed(fin_x[OW-1:0]);
      pixel_y <= $signed(fin_y[OW-1:0]);
      clipped <= fin_x[OW] | fin_y[OW];
    end
  end

  // checks
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !point_ready |-> (pixel_valid && !pixel_ready && vld[LAST]))
    else $error("input held off without an output stall");

  a_accept_enters_row: assert property (@(posedge clk) disable iff (rst)
    (point_valid && point_ready) |=> vld[0])
    else $error("accepted word missing from the first stage");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && clipped) |-> (pixel_x == PIX_MAX || pixel_x == PIX_MIN ||
                                  pixel_y == PIX_MAX || pixel_y == PIX_MIN))
    else $error("clipped set with no pixel at a limit");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=> (pixel_valid && $stable(pixel_x) && $stable(pixel_y)))
    else $error("waiting result overwritten by the pipeline");

endmodule

### tb/sv/top_down_view_projection_test.sv
// Testbench for the top-down view projection: directed table, then randomized points per setting.
`timescale 1ns / 100ps

module top_down_view_projection_test;
  import tdvp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 45;
  localparam int PHASE_POINTS = 72;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint ONE_Q = 64'sd1 <<< (FRAC + GUARD);
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cz;
    logic [YAW_W-1:0]          yaw;
  } point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic                    clip;
  } pixel_t;

  typedef struct packed {
    point_t pt;
    bit     typed;
    pixel_t want;
  } dir_row_t;

  typedef struct packed {
    bit               pick;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] r;
  } view_setting_t;

  // reset settings: W = H = 500, R = 25; zero offsets land on (250, 500)
  localparam int N_DIRECTED = 20;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'h0000}, 1'b1, '{16'sd250, 16'sd500, 1'b0}},
    '{'{32'sd1234, 32'sd1234, 32'sd1234, 32'sd1234, 16'h8000}, 1'b1,
      '{16'sd250, 16'sd500, 1'b0}},
    '{'{32'sd0, C_MIN, 32'sd0, C_MAX, 16'h0000}, 1'b1, '{16'sd250, -16'sd32768, 1'b1}},
    '{'{32'sd0, C_MAX, 32'sd0, C_MIN, 16'h0000}, 1'b1, '{16'sd250, 16'sd32767, 1'b1}},
    '{'{C_MIN, 32'sd0, C_MAX, 32'sd0, 16'h0000}, 1'b1, '{-16'sd32768, 16'sd500, 1'b1}},
    '{'{C_MAX, 32'sd0, C_MIN, 32'sd0, 16'h0000}, 1'b1, '{16'sd32767, 16'sd500, 1'b1}},
    '{'{C_MAX, C_MAX, C_MAX, C_MAX, 16'hFFFF}, 1'b1, '{16'sd250, 16'sd500, 1'b0}},
    '{'{C_MIN, C_MIN, C_MIN, C_MIN, 16'h4000}, 1'b1, '{16'sd250, 16'sd500, 1'b0}},
    '{'{32'sd2560, 32'sd1280, 32'sd0, 32'sd0, 16'h0000}, 1'b0, '0},
    '{'{32'sd2560, 32'sd1280, 32'sd0, 32'sd0, 16'h4000}, 1'b0, '0},
    '{'{32'sd2560, 32'sd1280, 32'sd0, 32'sd0, 16'h8000}, 1'b0, '0},
    '{'{32'sd2560, 32'sd1280, 32'sd0, 32'sd0, 16'hC000}, 1'b0, '0},
    '{'{32'sd2560, 32'sd1280, 32'sd0, 32'sd0, 16'h2000}, 1'b0, '0},
    '{'{32'sd2560, 32'sd1280, 32'sd0, 32'sd0, 16'h2001}, 1'b0, '0},
    '{'{32'sd2560, 32'sd1280, 32'sd0, 32'sd0, 16'h1FFF}, 1'b0, '0},
    '{'{32'sd2560, 32'sd1280, 32'sd0, 32'sd0, 16'hFFFF}, 1'b0, '0},
    '{'{-32'sd1, -32'sd1, 32'sd1, 32'sd1, 16'h5555}, 1'b0, '0},
    '{'{C_MAX, C_MIN, C_MIN, C_MAX, 16'hAAAA}, 1'b0, '0},
    '{'{-32'sd6400, 32'sd6400, 32'sd0, 32'sd0, 16'h6000}, 1'b0, '0},
    '{'{32'sd0, -32'sd6400, 32'sd0, 32'sd0, 16'h0000}, 1'b0, '0}
  };

  // zero range with zero width, and zero height, get their own phases
  localparam int N_PHASES = 9;
  localparam view_setting_t SETTINGS_LIST [N_PHASES] = '{
    '{1'b0, 12'd4095, 12'd4095, 12'd1},
    '{1'b0, 12'd1, 12'd1, 12'd4095},
    '{1'b0, 12'd0, 12'd300, 12'd0},
    '{1'b0, 12'd640, 12'd0, 12'd50},
    '{1'b1, 12'd0, 12'd0, 12'd0},
    '{1'b0, 12'd4095, 12'd4095, 12'd4095},
    '{1'b0, 12'd1, 12'd1, 12'd1},
    '{1'b1, 12'd0, 12'd0, 12'd0},
    '{1'b1, 12'd0, 12'd0, 12'd0}
  };

  logic clk;
  logic rst;
  logic point_valid;
  logic point_ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_z;
  logic signed [COORD_W-1:0] cam_x;
  logic signed [COORD_W-1:0] cam_z;
  logic [YAW_W-1:0] cam_yaw;
  logic pixel_valid;
  logic pixel_ready;
  logic signed [OUT_W-1:0] pixel_x;
  logic signed [OUT_W-1:0] pixel_y;
  logic clipped;
  logic cfg_write;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  logic [CFG_W-1:0] view_w;
  logic [CFG_W-1:0] view_h;
  logic [CFG_W-1:0] view_range;

  pixel_t pending_pixels[$];
  int errors;
  int points_sent;
  int pixels_checked;
  int idle_cycles;
  int sink_stall;
  bit calm;

  top_down_view_projection dut (
    .clk(clk),
    .rst(rst),
    .point_valid(point_valid),
    .point_ready(point_ready),
    .point_x(point_x),
    .point_z(point_z),
    .cam_x(cam_x),
    .cam_z(cam_z),
    .cam_yaw(cam_yaw),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .clipped(clipped),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Q30 sine and cosine of the yaw, octant folded, Horner series
  function automatic void yaw_sin_cos(input logic [YAW_W-1:0] yaw,
                                      output longint s_q, output longint c_q);
    logic [PH_W-1:0] phase;
    logic [1:0] quad;
    longint r, theta, x2, t, s, c, tmp;
    longint one;
    bit swap;
    one = longint'(TRIG_ONE);
    phase = (PH_W'(yaw) << 16) & ~((32'd1 << (32 - ANGLE_BITS_DEF)) - 32'd1);
    quad = phase[31:30];
    r = longint'(phase[29:0]);
    swap = 1'b0;
    if (r > 64'sh2000_0000) begin
      r = 64'sh4000_0000 - r;
      swap = 1'b1;
    end
    theta = (r * longint'(TWO_PI_Q30) + 64'sh8000_0000) >>> 32;
    x2 = (theta * theta + (64'sd1 <<< 29)) >>> 30;
    t = one;
    t = one - ((x2 * t) >>> 30) / 72;
    t = one - ((x2 * t) >>> 30) / 42;
    t = one - ((x2 * t) >>> 30) / 20;
    t = one - ((x2 * t) >>> 30) / 6;
    s = (theta * t) >>> 30;
    t = one;
    t = one - ((x2 * t) >>> 30) / 90;
    t = one - ((x2 * t) >>> 30) / 56;
    t = one - ((x2 * t) >>> 30) / 30;
    t = one - ((x2 * t) >>> 30) / 12;
    t = one - ((x2 * t) >>> 30) / 2;
    c = t;
    if (swap) begin
      tmp = s;
      s = c;
      c = tmp;
    end
    case (quad)
      2'd0: begin s_q = s; c_q = c; end
      2'd1: begin s_q = c; c_q = -s; end
      2'd2: begin s_q = -s; c_q = -c; end
      default: begin s_q = -c; c_q = s; end
    endcase
  endfunction

  function automatic pixel_t project_point(input point_t pt);
    longint dz, dx, s, c, fwd, lat, w, h, rng, den, ny, nx, yq, xq;
    pixel_t res;
    yaw_sin_cos(pt.yaw, s, c);
    dz = longint'($signed(pt.cz)) - longint'($signed(pt.pz));
    dx = longint'($signed(pt.cx)) - longint'($signed(pt.px));
    fwd = (dz * c - dx * s) >>> (TRIG_Q - GUARD);
    lat = (dz * s + dx * c) >>> (TRIG_Q - GUARD);
    w = longint'(view_w);
    h = longint'(view_h);
    rng = (view_range == '0) ? 64'sd1 : longint'(view_range);
    den = 2 * rng * ONE_Q;
    ny = w * (den - fwd);
    nx = h * (rng * ONE_Q - lat);
    yq = ny / den;
    xq = nx / den;
    res.clip = 1'b0;
    if (yq > 32767) begin
      yq = 32767;
      res.clip = 1'b1;
    end else if (yq < -32768) begin
      yq = -32768;
      res.clip = 1'b1;
    end
    if (xq > 32767) begin
      xq = 32767;
      res.clip = 1'b1;
    end else if (xq < -32768) begin
      xq = -32768;
      res.clip = 1'b1;
    end
    res.x = OUT_W'(xq);
    res.y = OUT_W'(yq);
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] edge_coord();
    case ($urandom_range(0, 4))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      3: return '1;
      default: return 32'sd1;
    endcase
  endfunction

  // mostly points inside the view around a random camera, some noise, some extremes
  function automatic point_t random_point();
    point_t pt;
    int unsigned kind, span;
    int off_x, off_z;
    kind = $urandom_range(0, 99);
    pt.cx = $urandom;
    pt.cz = $urandom;
    pt.yaw = $urandom;
    if (kind < 60) begin
      span = ((view_range == '0 ? 1 : int'(view_range)) * 2 + 2) * 256;
      off_x = int'($urandom_range(0, 2 * span)) - int'(span);
      off_z = int'($urandom_range(0, 2 * span)) - int'(span);
      pt.px = pt.cx - off_x;
      pt.pz = pt.cz - off_z;
    end else if (kind < 85) begin
      pt.px = $urandom;
      pt.pz = $urandom;
    end else begin
      pt.px = edge_coord();
      pt.pz = edge_coord();
      pt.cx = edge_coord();
      pt.cz = edge_coord();
      case ($urandom_range(0, 7))
        0: pt.yaw = 16'h0000;
        1: pt.yaw = 16'h2000;
        2: pt.yaw = 16'h4000;
        3: pt.yaw = 16'h8000;
        4: pt.yaw = 16'hC000;
        5: pt.yaw = 16'hFFFF;
        6: pt.yaw = 16'h2001;
        default: pt.yaw = 16'h1FFF;
      endcase
    end
    return pt;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_point(input point_t pt, input bit typed, input pixel_t want);
    if (!calm && $urandom_range(0, 99) < 15) begin
      point_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    point_valid = 1'b1;
    point_x = pt.px;
    point_z = pt.pz;
    cam_x = pt.cx;
    cam_z = pt.cz;
    cam_yaw = pt.yaw;
    do @(posedge clk); while (!point_ready);
    pending_pixels.push_back(typed ? want : project_point(pt));
    points_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      REG_VIEW_WIDTH: view_w = data;
      REG_VIEW_HEIGHT: view_h = data;
      REG_RANGE: view_range = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    point_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pixel_valid && pixel_ready) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("unexpected word x=%0d y=%0d clip=%0b",
                                pixel_x, pixel_y, clipped));
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (pixel_x !== want.x)
          flag_mismatch($sformatf("pixel_x got %0d want %0d", pixel_x, want.x));
        if (pixel_y !== want.y)
          flag_mismatch($sformatf("pixel_y got %0d want %0d", pixel_y, want.y));
        if (clipped !== want.clip)
          flag_mismatch($sformatf("clipped got %0b want %0b", clipped, want.clip));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (point_valid && point_ready) || (pixel_valid && pixel_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("top_down_view_projection_test failed");
      $finish;
    end
  end

  // output back-pressure in bursts
  initial begin
    pixel_ready = 1'b0;
    sink_stall = 0;
    forever begin
      @(negedge clk);
      if (sink_stall > 0) begin
        sink_stall--;
        pixel_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 10) begin
        sink_stall = $urandom_range(1, 12) - 1;
        pixel_ready = 1'b0;
      end else begin
        pixel_ready = 1'b1;
      end
    end
  end

  initial begin
    view_setting_t vs;
    clk = 1'b0;
    rst = 1'b1;
    point_valid = 1'b0;
    point_x = '0;
    point_z = '0;
    cam_x = '0;
    cam_z = '0;
    cam_yaw = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    points_sent = 0;
    pixels_checked = 0;
    idle_cycles = 0;
    calm = 1'b0;
    view_w = VIEW_WIDTH_RST;
    view_h = VIEW_HEIGHT_RST;
    view_range = RANGE_RST;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_point(DIRECTED[i].pt, DIRECTED[i].typed, DIRECTED[i].want);
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      vs = SETTINGS_LIST[ph];
      if (vs.pick) begin
        vs.w = $urandom_range(0, 4095);
        vs.h = $urandom_range(0, 4095);
        vs.r = $urandom_range(0, 4095);
      end
      write_reg(REG_VIEW_WIDTH, vs.w);
      write_reg(REG_VIEW_HEIGHT, vs.h);
      write_reg(REG_RANGE, vs.r);
      // an unmapped index must leave the registers alone
      if (ph == 7) write_reg(REG_UNUSED, $urandom);
      @(negedge clk);
      cfg_write = 1'b0;
      calm = (ph == N_PHASES - 1);
      for (int i = 0; i < PHASE_POINTS; i++)
        send_point(random_point(), 1'b0, '0);
      wait_drained();
    end

    if (pending_pixels.size() != 0)
      flag_mismatch($sformatf("%0d words never arrived", pending_pixels.size()));
    $display("sent %0d points (%0d directed) over %0d view settings, checked %0d words",
             points_sent, N_DIRECTED, N_PHASES + 1, pixels_checked);
    $display("settings included zero and full-scale width, height and range");
    if (errors == 0) begin
      $display("top_down_view_projection_test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("top_down_view_projection_test failed");
    end
    $finish;
  end

endmodule
